>>> design/dgf_pkg.sv
// Shared types and constants of the face-flux surface update block.
package dgf_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_NODE  = 2'd0,
        OP_WRITE_ELEM = 2'd1,
        OP_READ_ELEM  = 2'd2,
        OP_APPLY_FLUX = 2'd3
    } dgf_opcode_t;

    typedef enum logic [1:0] {
        FOP_MUL = 2'd0,
        FOP_SUB = 2'd1,
        FOP_DIV = 2'd2
    } dgf_fop_t;

    typedef struct packed {
        logic     start;
        dgf_fop_t op;
    } dgf_fpu_req_t;

    localparam logic [1:0] DIR_X = 2'd0;
    localparam logic [1:0] DIR_Y = 2'd1;
    localparam logic [1:0] DIR_Z = 2'd2;

    localparam logic [2:0] CFG_BASIS_SIZE   = 3'd0;
    localparam logic [2:0] CFG_VAR_COUNT    = 3'd1;
    localparam logic [2:0] CFG_CELL_WIDTH_X = 3'd2;
    localparam logic [2:0] CFG_CELL_WIDTH_Y = 3'd3;
    localparam logic [2:0] CFG_CELL_WIDTH_Z = 3'd4;

    localparam logic [63:0] DBL_ONE         = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] DBL_POS_QNAN    = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DBL_QUIET_BIT   = 64'h0008_0000_0000_0000;

endpackage

>>> design/dgf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dgf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/dgf_fpu.sv
// Shared multi-cycle IEEE double unit: multiply, subtract and divide with round to nearest even.
module dgf_fpu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dgf_pkg::dgf_fpu_req_t req,
    input  logic [63:0]          op_a,
    input  logic [63:0]          op_b,
    output logic                 done,
    output logic [63:0]          result
);

    typedef enum logic [3:0] {
        F_IDLE, F_PRE, F_MUL, F_ALIGN, F_ADD, F_DIV, F_NORM, F_DENORM, F_PACK
    } fstate_t;

    fstate_t             fst_reg;
    dgf_pkg::dgf_fop_t   fop_reg;
    logic                sa_reg, sb_reg, sign_reg;
    logic signed [13:0]  ea_reg, eb_reg, x_reg;
    logic [63:0]         ma_reg, mb_reg, pp_reg, nm_reg;
    logic [127:0]        r_reg, rb_reg;
    logic [64:0]         rem_reg;
    logic [6:0]          cnt_reg;
    logic [1:0]          kd_reg;
    logic                st_reg, done_reg;
    logic [13:0]         expm1_reg;
    logic [63:0]         res_reg;

    // operand classification
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sb_eff;
    logic spec_hit;
    logic [63:0] spec_val;

    always_comb begin
        a_nan  = (op_a[62:52] == 11'h7FF) && (op_a[51:0] != 52'd0);
        b_nan  = (op_b[62:52] == 11'h7FF) && (op_b[51:0] != 52'd0);
        a_inf  = (op_a[62:52] == 11'h7FF) && (op_a[51:0] == 52'd0);
        b_inf  = (op_b[62:52] == 11'h7FF) && (op_b[51:0] == 52'd0);
        a_zero = (op_a[62:0] == 63'd0);
        b_zero = (op_b[62:0] == 63'd0);
        sb_eff = (req.op == dgf_pkg::FOP_SUB) ? ~op_b[63] : op_b[63];
        spec_hit = 1'b1;
        spec_val = 64'd0;
        if (a_nan) begin
            spec_val = op_a | dgf_pkg::DBL_QUIET_BIT;
        end else if (b_nan) begin
            spec_val = op_b | dgf_pkg::DBL_QUIET_BIT;
        end else begin
            unique case (req.op)
                dgf_pkg::FOP_MUL: begin
                    if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                        spec_val = dgf_pkg::DBL_DEFAULT_NAN;
                    end else if (a_inf || b_inf) begin
                        spec_val = {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
                    end else if (a_zero || b_zero) begin
                        spec_val = {op_a[63] ^ op_b[63], 63'd0};
                    end else begin
                        spec_hit = 1'b0;
                    end
                end
                dgf_pkg::FOP_SUB: begin
                    if (a_inf && b_inf) begin
                        spec_val = (op_a[63] == sb_eff) ? op_a : dgf_pkg::DBL_DEFAULT_NAN;
                    end else if (a_inf) begin
                        spec_val = op_a;
                    end else if (b_inf) begin
                        spec_val = {sb_eff, 11'h7FF, 52'd0};
                    end else if (a_zero && b_zero) begin
                        spec_val = {op_a[63] & sb_eff, 63'd0};
                    end else if (a_zero) begin
                        spec_val = {sb_eff, op_b[62:0]};
                    end else if (b_zero) begin
                        spec_val = op_a;
                    end else begin
                        spec_hit = 1'b0;
                    end
                end
                dgf_pkg::FOP_DIV: begin
                    if (a_zero && b_zero) begin
                        spec_val = dgf_pkg::DBL_POS_QNAN;
                    end else if (a_inf && b_inf) begin
                        spec_val = dgf_pkg::DBL_DEFAULT_NAN;
                    end else if (a_inf || b_zero) begin
                        spec_val = {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
                    end else if (a_zero || b_inf) begin
                        spec_val = {op_a[63] ^ op_b[63], 63'd0};
                    end else begin
                        spec_hit = 1'b0;
                    end
                end
                default: begin
                    spec_hit = 1'b0;
                end
            endcase
        end
    end

    // alignment for subtract: shift the smaller operand right, jam lost bits into bit 0
    logic signed [14:0] ediff;
    logic [127:0]       ra_full, rb_full, al_src, al_shifted, al_out;
    logic [7:0]         al_sh;
    logic               al_lost;

    always_comb begin
        ediff   = 15'(ea_reg) - 15'(eb_reg);
        ra_full = {1'b0, ma_reg, 63'd0};
        rb_full = {1'b0, mb_reg, 63'd0};
        if (ediff >= 0) begin
            al_src = rb_full;
            al_sh  = (ediff >= 15'sd128) ? 8'd128 : 8'(ediff);
        end else begin
            al_src = ra_full;
            al_sh  = (ediff <= -15'sd128) ? 8'd128 : 8'(-ediff);
        end
        al_shifted = al_src >> al_sh;
        al_lost    = ((al_shifted << al_sh) != al_src);
        al_out     = al_shifted | {127'd0, al_lost};
    end

    // one restoring division step
    logic        dv_ge;
    logic [64:0] dv_diff;

    always_comb begin
        dv_ge   = (rem_reg >= {1'b0, mb_reg});
        dv_diff = dv_ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
    end

    // subnormal shift and final rounding
    logic signed [13:0] biased, shamt;
    logic [63:0]        dn_n, dn_nm;
    logic               dn_st;
    logic [13:0]        dn_expm1;
    logic [52:0]        mant53;
    logic               rnd_inc;
    logic [53:0]        m54;
    logic [65:0]        packed_sum;

    always_comb begin
        biased   = x_reg + 14'sd1023;
        shamt    = 14'sd1 - biased;
        dn_n     = r_reg[127:64];
        dn_st    = |r_reg[63:0];
        dn_nm    = dn_n;
        dn_expm1 = 14'd0;
        if (biased > 14'sd0) begin
            dn_expm1 = 14'(biased - 14'sd1);
        end else if (shamt >= 14'sd64) begin
            dn_nm = 64'd0;
            dn_st = 1'b1;
        end else begin
            dn_nm = dn_n >> shamt[5:0];
            dn_st = dn_st | ((dn_nm << shamt[5:0]) != dn_n);
        end
        mant53     = nm_reg[63:11];
        rnd_inc    = nm_reg[10] & ((|nm_reg[9:0]) | st_reg | mant53[0]);
        m54        = {1'b0, mant53} + {53'd0, rnd_inc};
        packed_sum = {expm1_reg, 52'd0} + {12'd0, m54};
    end

    logic [31:0] mul_ha, mul_hb;

    always_comb begin
        mul_ha = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        mul_hb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fst_reg  <= F_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (fst_reg)
                F_IDLE: begin
                    if (req.start) begin
                        fop_reg <= req.op;
                        sa_reg  <= op_a[63];
                        sb_reg  <= sb_eff;
                        sign_reg <= op_a[63] ^ op_b[63];
                        ma_reg  <= {(op_a[62:52] != 11'd0), op_a[51:0], 11'd0};
                        mb_reg  <= {(op_b[62:52] != 11'd0), op_b[51:0], 11'd0};
                        ea_reg  <= (op_a[62:52] != 11'd0) ?
                                   $signed({3'd0, op_a[62:52]}) - 14'sd1023 : -14'sd1022;
                        eb_reg  <= (op_b[62:52] != 11'd0) ?
                                   $signed({3'd0, op_b[62:52]}) - 14'sd1023 : -14'sd1022;
                        if (spec_hit) begin
                            res_reg  <= spec_val;
                            done_reg <= 1'b1;
                        end else begin
                            fst_reg <= F_PRE;
                        end
                    end
                end
                F_PRE: begin
                    // normalise subnormal operands, eight places at a time where possible
                    if (!ma_reg[63]) begin
                        if (ma_reg[63:56] == 8'd0) begin
                            ma_reg <= ma_reg << 8;
                            ea_reg <= ea_reg - 14'sd8;
                        end else begin
                            ma_reg <= ma_reg << 1;
                            ea_reg <= ea_reg - 14'sd1;
                        end
                    end
                    if (!mb_reg[63]) begin
                        if (mb_reg[63:56] == 8'd0) begin
                            mb_reg <= mb_reg << 8;
                            eb_reg <= eb_reg - 14'sd8;
                        end else begin
                            mb_reg <= mb_reg << 1;
                            eb_reg <= eb_reg - 14'sd1;
                        end
                    end
                    if (ma_reg[63] && mb_reg[63]) begin
                        r_reg   <= 128'd0;
                        rem_reg <= {1'b0, ma_reg};
                        cnt_reg <= 7'd0;
                        unique case (fop_reg)
                            dgf_pkg::FOP_MUL: fst_reg <= F_MUL;
                            dgf_pkg::FOP_SUB: fst_reg <= F_ALIGN;
                            dgf_pkg::FOP_DIV: fst_reg <= F_DIV;
                            default:          fst_reg <= F_MUL;
                        endcase
                    end
                end
                F_MUL: begin
                    // four 32x32 partial products, each registered before it is summed
                    if (cnt_reg < 7'd4) begin
                        pp_reg <= mul_ha * mul_hb;
                        kd_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    end
                    if (cnt_reg != 7'd0) begin
                        r_reg <= r_reg + ({64'd0, pp_reg} << {kd_reg, 5'd0});
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd4) begin
                        x_reg   <= ea_reg + eb_reg + 14'sd1;
                        fst_reg <= F_NORM;
                    end
                end
                F_ALIGN: begin
                    if (ediff >= 0) begin
                        r_reg  <= ra_full;
                        rb_reg <= al_out;
                        x_reg  <= ea_reg + 14'sd1;
                    end else begin
                        r_reg  <= al_out;
                        rb_reg <= rb_full;
                        x_reg  <= eb_reg + 14'sd1;
                    end
                    fst_reg <= F_ADD;
                end
                F_ADD: begin
                    if (sa_reg == sb_reg) begin
                        r_reg    <= r_reg + rb_reg;
                        sign_reg <= sa_reg;
                    end else if (r_reg >= rb_reg) begin
                        r_reg    <= r_reg - rb_reg;
                        sign_reg <= (r_reg == rb_reg) ? 1'b0 : sa_reg;
                    end else begin
                        r_reg    <= rb_reg - r_reg;
                        sign_reg <= sb_reg;
                    end
                    fst_reg <= F_NORM;
                end
                F_DIV: begin
                    rem_reg <= {dv_diff[63:0], 1'b0};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd65) begin
                        // quotient to the top, remainder becomes the sticky bit
                        r_reg   <= {r_reg[64:0], dv_ge, 61'd0, (dv_diff != 65'd0)};
                        x_reg   <= ea_reg - eb_reg;
                        fst_reg <= F_NORM;
                    end else begin
                        r_reg <= {r_reg[126:0], dv_ge};
                    end
                end
                F_NORM: begin
                    if (r_reg == 128'd0) begin
                        res_reg  <= {sign_reg, 63'd0};
                        done_reg <= 1'b1;
                        fst_reg  <= F_IDLE;
                    end else if (r_reg[127]) begin
                        fst_reg <= F_DENORM;
                    end else if (r_reg[127:120] == 8'd0) begin
                        r_reg <= r_reg << 8;
                        x_reg <= x_reg - 14'sd8;
                    end else begin
                        r_reg <= r_reg << 1;
                        x_reg <= x_reg - 14'sd1;
                    end
                end
                F_DENORM: begin
                    nm_reg    <= dn_nm;
                    st_reg    <= dn_st;
                    expm1_reg <= dn_expm1;
                    fst_reg   <= F_PACK;
                end
                F_PACK: begin
                    if (packed_sum[65:52] >= 14'd2047) begin
                        res_reg <= {sign_reg, 11'h7FF, 52'd0};
                    end else begin
                        res_reg <= {sign_reg, packed_sum[62:0]};
                    end
                    done_reg <= 1'b1;
                    fst_reg  <= F_IDLE;
                end
                default: begin
                    fst_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> design/dg_face_flux_surface_update.sv
// Top level of the face-flux surface update: cube and node tables, sequencer, output register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------------
//  input    | s_tvalid / s_tready        | s_tuser opcode, s_tdata node and value fields
//  result   | m_tvalid / m_tready        | m_tdata read_value (element reads only)
//  config   | cfg_wr_en                  | cfg_index, cfg_wdata
//
//  Table load and element write are taken on acceptance; an element read passes S_READ and
//  S_READ_OUT, where it can stall. A flux request computes the weight product and division,
//  then works node by node: every double operation goes through the one shared arithmetic unit.
//  Synchronous active-low reset clears the sequencer, output valid and the configuration registers;
//  cube and tables hold nothing defined until written. A full result register only holds
//  the sequencer when the next element read finishes.
module dg_face_flux_surface_update #(
    parameter int MAX_BASIS = 8,
    parameter int MAX_VARS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // direction[1:0], node_a[4:2], node_b[7:5], node_c[10:8], variable[14:11],
    // value_a[78:15], value_b[142:79], value_c[206:143], zero pad[207]
    input  logic [207:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_value[63:0]
    output logic [63:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

    localparam int TAW        = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
    localparam int CUBE_DEPTH = MAX_BASIS * MAX_BASIS * MAX_BASIS * MAX_VARS;
    localparam int CAW        = (CUBE_DEPTH > 1) ? $clog2(CUBE_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_READ_OUT, S_W_A, S_W_B, S_W_CAP, S_FPU, S_L_RD, S_L_CAP
    } state_t;

    typedef enum logic [2:0] {
        ST_WEIGHT, ST_SCALE, ST_PR, ST_PL, ST_DIFF, ST_DELTA, ST_ELEM
    } step_t;

    function automatic logic [CAW-1:0] cube_addr(input logic [3:0] ca, input logic [3:0] cb,
                                                 input logic [3:0] cc, input logic [3:0] cv);
        int t;
        t = ((int'(ca) * MAX_BASIS + int'(cb)) * MAX_BASIS + int'(cc)) * MAX_VARS + int'(cv);
        return CAW'(t);
    endfunction

    // configuration registers
    logic [3:0]  basis_size_reg;
    logic [4:0]  var_count_reg;
    logic [63:0] cell_width_x_reg, cell_width_y_reg, cell_width_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_size_reg   <= 4'd8;
            var_count_reg    <= 5'd1;
            cell_width_x_reg <= dgf_pkg::DBL_ONE;
            cell_width_y_reg <= dgf_pkg::DBL_ONE;
            cell_width_z_reg <= dgf_pkg::DBL_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dgf_pkg::CFG_BASIS_SIZE:   basis_size_reg   <= cfg_wdata[3:0];
                dgf_pkg::CFG_VAR_COUNT:    var_count_reg    <= cfg_wdata[4:0];
                dgf_pkg::CFG_CELL_WIDTH_X: cell_width_x_reg <= cfg_wdata;
                dgf_pkg::CFG_CELL_WIDTH_Y: cell_width_y_reg <= cfg_wdata;
                dgf_pkg::CFG_CELL_WIDTH_Z: cell_width_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input field decode
    dgf_pkg::dgf_opcode_t in_op;
    logic [1:0]  in_dir;
    logic [2:0]  in_a, in_b, in_c;
    logic [3:0]  in_var;
    logic [63:0] in_va, in_vb, in_vc;

    assign in_op  = dgf_pkg::dgf_opcode_t'(s_tuser);
    assign in_dir = s_tdata[1:0];
    assign in_a   = s_tdata[4:2];
    assign in_b   = s_tdata[7:5];
    assign in_c   = s_tdata[10:8];
    assign in_var = s_tdata[14:11];
    assign in_va  = s_tdata[78:15];
    assign in_vb  = s_tdata[142:79];
    assign in_vc  = s_tdata[206:143];

    logic [4:0] nb;
    logic [6:0] nv;
    logic       elem_ok, flux_ok, node_ok, accept;

    always_comb begin
        nb = ({1'b0, basis_size_reg} < 5'(MAX_BASIS)) ? {1'b0, basis_size_reg} : 5'(MAX_BASIS);
        nv = ({2'b0, var_count_reg} < 7'(MAX_VARS)) ? {2'b0, var_count_reg} : 7'(MAX_VARS);
        elem_ok = ({2'b0, in_a} < nb) && ({2'b0, in_b} < nb) && ({2'b0, in_c} < nb)
                  && ({3'b0, in_var} < nv);
        flux_ok = (in_dir != 2'd3) && ({2'b0, in_a} < nb) && ({2'b0, in_b} < nb)
                  && ({3'b0, in_var} < nv);
        node_ok = (5'(in_a) < 5'(MAX_BASIS));
    end

    state_t      state_reg;
    step_t       step_reg;
    logic [1:0]  dir_reg;
    logic [2:0]  a_reg, b_reg;
    logic [3:0]  var_reg, l_reg;
    logic [63:0] left_reg, right_reg, wa_reg, lc_reg, pr_reg, scale_reg, elem_reg;
    logic [CAW-1:0] idx_reg;
    logic        rd_ok_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // memories
    logic           tab_we;
    logic [TAW-1:0] tab_waddr, tab_raddr;
    logic [191:0]   tab_wdata, tab_rdata;
    logic           cube_we;
    logic [CAW-1:0] cube_waddr, cube_raddr, idx_l;
    logic [63:0]    cube_wdata, cube_rdata;

    dgf_ram #(.WIDTH(192), .DEPTH(MAX_BASIS)) u_tab (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    dgf_ram #(.WIDTH(64), .DEPTH(CUBE_DEPTH)) u_cube (
        .aclk  (aclk),
        .we    (cube_we),
        .waddr (cube_waddr),
        .wdata (cube_wdata),
        .raddr (cube_raddr),
        .rdata (cube_rdata)
    );

    // shared arithmetic unit
    dgf_pkg::dgf_fpu_req_t fpu_req;
    logic [63:0] fpu_a, fpu_b, fpu_res, dx_sel;
    logic        fpu_done;

    dgf_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .op_a    (fpu_a),
        .op_b    (fpu_b),
        .done    (fpu_done),
        .result  (fpu_res)
    );

    always_comb begin
        unique case (dir_reg)
            dgf_pkg::DIR_X: idx_l = cube_addr({1'b0, a_reg}, {1'b0, b_reg}, l_reg, var_reg);
            dgf_pkg::DIR_Y: idx_l = cube_addr({1'b0, a_reg}, l_reg, {1'b0, b_reg}, var_reg);
            default:        idx_l = cube_addr(l_reg, {1'b0, a_reg}, {1'b0, b_reg}, var_reg);
        endcase
        unique case (dir_reg)
            dgf_pkg::DIR_X: dx_sel = cell_width_x_reg;
            dgf_pkg::DIR_Y: dx_sel = cell_width_y_reg;
            default:        dx_sel = cell_width_z_reg;
        endcase
    end

    always_comb begin
        tab_we     = accept && (in_op == dgf_pkg::OP_LOAD_NODE) && node_ok;
        tab_waddr  = TAW'(in_a);
        tab_wdata  = {in_vc, in_vb, in_va};
        unique case (state_reg)
            S_W_A:   tab_raddr = TAW'(a_reg);
            S_W_B:   tab_raddr = TAW'(b_reg);
            default: tab_raddr = TAW'(l_reg);
        endcase

        cube_raddr = (state_reg == S_L_RD) ? idx_l : idx_reg;
        if (accept) begin
            cube_we    = (in_op == dgf_pkg::OP_WRITE_ELEM) && elem_ok;
            cube_waddr = cube_addr({1'b0, in_a}, {1'b0, in_b}, {1'b0, in_c}, in_var);
            cube_wdata = in_va;
        end else begin
            cube_we    = (state_reg == S_FPU) && fpu_done && (step_reg == ST_ELEM);
            cube_waddr = idx_reg;
            cube_wdata = fpu_res;
        end
    end

    always_comb begin
        fpu_req.start = 1'b0;
        fpu_req.op    = dgf_pkg::FOP_MUL;
        fpu_a         = 64'd0;
        fpu_b         = 64'd0;
        unique case (state_reg)
            S_W_CAP: begin
                fpu_req.start = 1'b1;
                fpu_a         = wa_reg;
                fpu_b         = tab_rdata[63:0];
            end
            S_L_CAP: begin
                fpu_req.start = 1'b1;
                fpu_a         = right_reg;
                fpu_b         = tab_rdata[127:64];
            end
            S_FPU: begin
                if (fpu_done) begin
                    unique case (step_reg)
                        ST_WEIGHT: begin
                            fpu_req.start = 1'b1;
                            fpu_req.op    = dgf_pkg::FOP_DIV;
                            fpu_a         = fpu_res;
                            fpu_b         = dx_sel;
                        end
                        ST_PR: begin
                            fpu_req.start = 1'b1;
                            fpu_a         = left_reg;
                            fpu_b         = lc_reg;
                        end
                        ST_PL: begin
                            fpu_req.start = 1'b1;
                            fpu_req.op    = dgf_pkg::FOP_SUB;
                            fpu_a         = pr_reg;
                            fpu_b         = fpu_res;
                        end
                        ST_DIFF: begin
                            fpu_req.start = 1'b1;
                            fpu_a         = fpu_res;
                            fpu_b         = scale_reg;
                        end
                        ST_DELTA: begin
                            fpu_req.start = 1'b1;
                            fpu_req.op    = dgf_pkg::FOP_SUB;
                            fpu_a         = elem_reg;
                            fpu_b         = fpu_res;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_READ_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        dir_reg   <= in_dir;
                        a_reg     <= in_a;
                        b_reg     <= in_b;
                        var_reg   <= in_var;
                        left_reg  <= in_va;
                        right_reg <= in_vb;
                        idx_reg   <= cube_addr({1'b0, in_a}, {1'b0, in_b}, {1'b0, in_c}, in_var);
                        rd_ok_reg <= elem_ok;
                        if (in_op == dgf_pkg::OP_READ_ELEM) begin
                            state_reg <= S_READ;
                        end else if ((in_op == dgf_pkg::OP_APPLY_FLUX) && flux_ok) begin
                            state_reg <= S_W_A;
                        end
                    end
                end
                S_READ: begin
                    state_reg <= S_READ_OUT;
                end
                S_READ_OUT: begin
                    // hold until the result register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= rd_ok_reg ? cube_rdata : 64'd0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_W_A: begin
                    state_reg <= S_W_B;
                end
                S_W_B: begin
                    wa_reg    <= tab_rdata[63:0];
                    state_reg <= S_W_CAP;
                end
                S_W_CAP: begin
                    step_reg  <= ST_WEIGHT;
                    state_reg <= S_FPU;
                end
                S_L_RD: begin
                    idx_reg   <= idx_l;
                    state_reg <= S_L_CAP;
                end
                S_L_CAP: begin
                    lc_reg    <= tab_rdata[191:128];
                    elem_reg  <= cube_rdata;
                    step_reg  <= ST_PR;
                    state_reg <= S_FPU;
                end
                S_FPU: begin
                    if (fpu_done) begin
                        unique case (step_reg)
                            ST_WEIGHT: step_reg <= ST_SCALE;
                            ST_SCALE: begin
                                scale_reg <= fpu_res;
                                l_reg     <= 4'd0;
                                state_reg <= S_L_RD;
                            end
                            ST_PR: begin
                                pr_reg   <= fpu_res;
                                step_reg <= ST_PL;
                            end
                            ST_PL:    step_reg <= ST_DIFF;
                            ST_DIFF:  step_reg <= ST_DELTA;
                            ST_DELTA: step_reg <= ST_ELEM;
                            ST_ELEM: begin
                                // advance to the next node along the direction
                                l_reg <= l_reg + 4'd1;
                                if ({1'b0, l_reg} + 5'd1 < nb) begin
                                    state_reg <= S_L_RD;
                                end else begin
                                    state_reg <= S_IDLE;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sim/dg_face_flux_surface_update_checker.sv
// Checker for the face-flux surface update: watches the input, result and config channels, predicts reads, compares.
module dg_face_flux_surface_update_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [207:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    output int           mismatch_count,
    output int           reads_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB_MAX = 8;
    localparam int NV_MAX = 16;

    logic [63:0] cube_bits [NB_MAX*NB_MAX*NB_MAX*NV_MAX];
    logic [63:0] weight_tab [NB_MAX];
    logic [63:0] rcoef_tab [NB_MAX];
    logic [63:0] lcoef_tab [NB_MAX];
    logic [3:0]  basis_reg;
    logic [4:0]  vars_reg;
    logic [63:0] width_reg [3];
    logic [63:0] read_values_due [$];

    assign reads_pending = read_values_due.size();

    function automatic int cube_addr(int a, int b, int c, int v);
        return ((a * NB_MAX + b) * NB_MAX + c) * NV_MAX + v;
    endfunction

    // IEEE quotient with a zero divisor worked out by hand
    function automatic real flux_scale(real num, logic [63:0] den_bits);
        logic [63:0] nbits;
        real den;
        nbits = $realtobits(num);
        den = $bitstoreal(den_bits);
        if (den != 0.0)
            return num / den;
        if (num != num)
            return $bitstoreal(nbits | dgf_pkg::DBL_QUIET_BIT);
        if (num == 0.0)
            return $bitstoreal(dgf_pkg::DBL_POS_QNAN);
        return $bitstoreal(((nbits ^ den_bits) & 64'h8000_0000_0000_0000)
                           | 64'h7FF0_0000_0000_0000);
    endfunction

    task automatic apply_request(input logic [1:0] op, input logic [207:0] d);
        logic [1:0]  dir;
        int          a, b, c, v, nb, nv, idx;
        logic [63:0] va, vb, vc;
        bit          in_range;
        real         scale, pr, pl, diff, delta;
        dir = d[1:0];
        a   = d[4:2];
        b   = d[7:5];
        c   = d[10:8];
        v   = d[14:11];
        va  = d[78:15];
        vb  = d[142:79];
        vc  = d[206:143];
        nb  = (basis_reg < NB_MAX) ? basis_reg : NB_MAX;
        nv  = (vars_reg < NV_MAX) ? vars_reg : NV_MAX;
        in_range = a < nb && b < nb && c < nb && v < nv;
        case (dgf_pkg::dgf_opcode_t'(op))
            dgf_pkg::OP_LOAD_NODE: begin
                weight_tab[a] = va;
                rcoef_tab[a]  = vb;
                lcoef_tab[a]  = vc;
            end
            dgf_pkg::OP_WRITE_ELEM: begin
                if (in_range)
                    cube_bits[cube_addr(a, b, c, v)] = va;
            end
            dgf_pkg::OP_READ_ELEM: begin
                read_values_due.push_back(in_range ? cube_bits[cube_addr(a, b, c, v)] : 64'd0);
            end
            default: begin
                if (dir <= dgf_pkg::DIR_Z && a < nb && b < nb && v < nv) begin
                    scale = flux_scale($bitstoreal(weight_tab[a]) * $bitstoreal(weight_tab[b]),
                                       width_reg[dir]);
                    for (int l = 0; l < nb; l++) begin
                        if (dir == dgf_pkg::DIR_X)
                            idx = cube_addr(a, b, l, v);
                        else if (dir == dgf_pkg::DIR_Y)
                            idx = cube_addr(a, l, b, v);
                        else
                            idx = cube_addr(l, a, b, v);
                        pr = $bitstoreal(vb) * $bitstoreal(rcoef_tab[l]);
                        pl = $bitstoreal(va) * $bitstoreal(lcoef_tab[l]);
                        diff = pr - pl;
                        delta = diff * scale;
                        cube_bits[idx] = $realtobits($bitstoreal(cube_bits[idx]) - delta);
                    end
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg <= 4'd8;
            vars_reg <= 5'd1;
            for (int k = 0; k < 3; k++)
                width_reg[k] <= dgf_pkg::DBL_ONE;
            mismatch_count <= 0;
            read_values_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dgf_pkg::CFG_BASIS_SIZE:   basis_reg <= cfg_wdata[3:0];
                    dgf_pkg::CFG_VAR_COUNT:    vars_reg <= cfg_wdata[4:0];
                    dgf_pkg::CFG_CELL_WIDTH_X: width_reg[0] <= cfg_wdata;
                    dgf_pkg::CFG_CELL_WIDTH_Y: width_reg[1] <= cfg_wdata;
                    dgf_pkg::CFG_CELL_WIDTH_Z: width_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (read_values_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected read result %h", m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    if (m_tdata !== read_values_due[0]) begin
                        if (mismatch_count < 10)
                            $display("read_value mismatch: expected %h actual %h",
                                     read_values_due[0], m_tdata);
                        mismatch_count <= mismatch_count + 1;
                    end
                    void'(read_values_due.pop_front());
                end
            end
        end
    end
endmodule

>>> sim/dg_face_flux_surface_update_tb.sv
// Testbench top: stimulus for the face-flux surface update and the final verdict.
module dg_face_flux_surface_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 1000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_wdata = '0;
    int           mismatch_count;
    int           reads_pending;

    bit           elem_written [8*8*8*16];
    int           nodes_in_use = 8;
    int           vars_in_use = 1;
    int           idle_cycles = 0;
    int           ready_hold = 0;

    dg_face_flux_surface_update dut (.*);

    dg_face_flux_surface_update_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // finite, non-zero double of moderate magnitude
    function automatic logic [63:0] random_double();
        logic [63:0] d;
        d[63] = $urandom_range(0, 1);
        d[62:52] = 11'd1023 + 11'($urandom_range(0, 40)) - 11'd20;
        d[51:0] = {$urandom, $urandom};
        return d;
    endfunction

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(input dgf_pkg::dgf_opcode_t op, input logic [1:0] dir,
                        input int a, b, c, v, input logic [63:0] va, vb, vc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser <= op;
        s_tdata <= {1'b0, vc, vb, va, 4'(v), 3'(c), 3'(b), 3'(a), dir};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic int elem_addr(int a, b, c, v);
        return ((a * 8 + b) * 8 + c) * 16 + v;
    endfunction

    function automatic bit elem_in_range(int a, b, c, v);
        return a < nodes_in_use && b < nodes_in_use && c < nodes_in_use && v < vars_in_use;
    endfunction

    task automatic write_elem(input int a, b, c, v, input logic [63:0] val);
        send(dgf_pkg::OP_WRITE_ELEM, dgf_pkg::DIR_X, a, b, c, v, val, random_double(),
             random_double());
        if (elem_in_range(a, b, c, v))
            elem_written[elem_addr(a, b, c, v)] = 1'b1;
    endtask

    // never read an element that holds nothing defined
    task automatic read_elem(input int a, b, c, v);
        if (elem_in_range(a, b, c, v) && !elem_written[elem_addr(a, b, c, v)])
            write_elem(a, b, c, v, random_double());
        send(dgf_pkg::OP_READ_ELEM, dgf_pkg::DIR_X, a, b, c, v, random_double(),
             random_double(), random_double());
    endtask

    task automatic apply_flux(input logic [1:0] dir, input int i, j, v,
                              input logic [63:0] left, right);
        if (dir <= dgf_pkg::DIR_Z && i < nodes_in_use && j < nodes_in_use
            && v < vars_in_use) begin
            for (int l = 0; l < nodes_in_use; l++) begin
                if (dir == dgf_pkg::DIR_X) read_elem_fill(i, j, l, v);
                else if (dir == dgf_pkg::DIR_Y) read_elem_fill(i, l, j, v);
                else read_elem_fill(l, i, j, v);
            end
        end
        send(dgf_pkg::OP_APPLY_FLUX, dir, i, j, $urandom_range(0, 7), v, left, right,
             random_double());
    endtask

    task automatic read_elem_fill(input int a, b, c, v);
        if (!elem_written[elem_addr(a, b, c, v)])
            write_elem(a, b, c, v, random_double());
    endtask

    task automatic load_node(input int n);
        send(dgf_pkg::OP_LOAD_NODE, dgf_pkg::DIR_X, n, $urandom_range(0, 7),
             $urandom_range(0, 7), $urandom_range(0, 15), random_double(), random_double(),
             random_double());
    endtask

    // let every read come back and any flux finish before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reads_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [3:0] nb, input logic [4:0] nv,
                              input logic [63:0] wx, wy, wz);
        logic [63:0] vals [5];
        vals = '{64'(nb), 64'(nv), wx, wy, wz};
        for (int k = 0; k < 5; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(k);
            cfg_wdata <= vals[k];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        nodes_in_use = (nb < 8) ? nb : 8;
        vars_in_use = (nv < 16) ? nv : 16;
    endtask

    task automatic random_items(input int count);
        int lim;
        lim = (nodes_in_use > 0) ? nodes_in_use - 1 : 0;
        for (int n = 0; n < count; n++) begin
            int r, a, b, c, v;
            r = $urandom_range(0, 99);
            // mostly in range, now and then anywhere
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom_range(0, 7); b = $urandom_range(0, 7);
                c = $urandom_range(0, 7); v = $urandom_range(0, 15);
            end else begin
                a = $urandom_range(0, lim); b = $urandom_range(0, lim);
                c = $urandom_range(0, lim);
                v = $urandom_range(0, (vars_in_use > 0) ? vars_in_use - 1 : 0);
            end
            if (r < 30)
                apply_flux((r < 2) ? 2'd3 : 2'($urandom_range(0, 2)), a, b, v,
                           random_double(), random_double());
            else if (r < 60)
                read_elem(a, b, c, v);
            else if (r < 88)
                write_elem(a, b, c, v, random_double());
            else
                load_node($urandom_range(0, 7));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: tables, field extremes, every operation, the ignored cases
        for (int n = 0; n < 8; n++)
            load_node(n);
        write_elem(0, 0, 0, 0, 64'd0);
        write_elem(7, 7, 7, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        read_elem(7, 7, 7, 0);
        read_elem(0, 0, 0, 0);
        elem_written[elem_addr(7, 7, 7, 0)] = 1'b0;
        write_elem(1, 2, 3, 15, random_double());
        read_elem(1, 2, 3, 15);
        read_elem(7, 7, 7, 15);
        apply_flux(dgf_pkg::DIR_X, 0, 0, 0, random_double(), random_double());
        apply_flux(dgf_pkg::DIR_Y, 7, 7, 0, random_double(), random_double());
        apply_flux(dgf_pkg::DIR_Z, 3, 4, 0, 64'd0, random_double());
        apply_flux(2'd3, 1, 1, 0, random_double(), random_double());
        apply_flux(dgf_pkg::DIR_X, 1, 1, 9, random_double(), random_double());
        read_elem(0, 0, 5, 0);
        read_elem(7, 3, 7, 0);
        read_elem(3, 4, 7, 0);
        settle();

        set_config(4'd2, 5'd2, random_double(), random_double(), random_double());
        random_items(40);
        settle();
        set_config(4'd8, 5'd16, random_double(), random_double(), random_double());
        random_items(40);
        settle();
        set_config(4'd0, 5'd0, random_double(), random_double(), random_double());
        random_items(20);
        settle();
        set_config(4'd15, 5'd31, random_double() | 64'h8000_0000_0000_0000,
                   random_double() | 64'h8000_0000_0000_0000, random_double());
        random_items(40);
        settle();
        set_config(4'd1, 5'd1, random_double(), random_double(), random_double());
        random_items(30);
        settle();

        // zero cell widths: disjoint lines so infinities never meet
        set_config(4'd2, 5'd1, 64'd0, 64'h8000_0000_0000_0000, random_double());
        apply_flux(dgf_pkg::DIR_X, 0, 0, 0, 64'd0, random_double());
        apply_flux(dgf_pkg::DIR_Y, 1, 1, 0, 64'd0, random_double());
        read_elem(0, 0, 0, 0);
        read_elem(0, 0, 1, 0);
        read_elem(1, 0, 1, 0);
        read_elem(1, 1, 1, 0);
        settle();
        elem_written = '{default: 1'b0};

        set_config(4'd4, 5'd3, random_double(), random_double(), random_double());
        random_items(50);
        settle();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
